// File: hdl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, idle while reset is low.
`define DFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on the rising clock edge, also during reset.
`define DFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: hdl/dfr_pkg.sv
// Package: types, codes and constants of the frame deframer.
package dfr_pkg;

    // Parse phase, one-hot.
    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    // Error codes carried by a result.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_HEADER   = 2'd1;
    localparam logic [1:0] ERR_UNMASKED = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG = 2'd3;

    // Header bit fields.
    localparam logic [7:0] RSV_MASK   = 8'h70;
    localparam logic [7:0] FIN_BIT    = 8'h80;
    localparam logic [7:0] MASK_BIT   = 8'h80;
    localparam logic [7:0] LEN7_MASK  = 8'h7F;
    localparam logic [3:0] OPCODE_MASK = 4'hF;
    localparam logic [6:0] LEN_EXT16  = 7'd126;
    localparam logic [6:0] LEN_EXT64  = 7'd127;

    // Extended length bytes still to come after the first one.
    localparam logic [2:0] EXT16_REST = 3'd1;
    localparam logic [2:0] EXT64_REST = 3'd7;

    localparam logic [31:0] MAX_FRAME_RESET = 32'd65536;

    // Width of the packed sideband on the result channel.
    localparam int unsigned USER_W = 7;

    // One result item.
    typedef struct packed {
        logic [1:0] error_kind;
        logic       frame_last;
        logic [3:0] frame_opcode;
        logic       has_data;
        logic [7:0] payload_byte;
    } result_t;

endpackage

// File: hdl/dfr_parser.sv
// Parser: input register, header/length/key state and payload unmasking.
`include "assert_macros.svh"

module dfr_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic [31:0]        max_frame_bytes,
    input  logic               buf_ready,
    output logic               res_valid,
    output dfr_pkg::result_t   res
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              fire;

    dfr_pkg::phase_t   phase_reg, phase_next;
    logic [3:0]        hdr_flags_reg, hdr_flags_next;
    logic [3:0]        opcode_reg, opcode_next;
    logic [63:0]       accum_reg, accum_next;
    logic [2:0]        ext_count_reg, ext_count_next;
    logic [31:0]       mask_key_reg, mask_key_next;
    logic [31:0]       left_reg, left_next;
    logic [1:0]        key_index_reg, key_index_next;
    logic              failed_reg, failed_next;

    logic [6:0]        len7;
    logic [63:0]       accum_shift;
    logic [63:0]       len_final;
    logic              len_too_long;
    logic [7:0]        key_byte;
    logic [31:0]       left_dec;

    // Input register: load when empty or when its byte moves on.
    assign s_tready = !in_valid_reg || buf_ready;
    assign fire     = in_valid_reg && buf_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Length helpers: 7-bit field, extended shift-in and final compare.
    assign len7         = in_byte_reg[6:0] & dfr_pkg::LEN7_MASK[6:0];
    assign accum_shift  = {accum_reg[55:0], in_byte_reg};
    assign len_final    = (phase_reg == dfr_pkg::PH_HDR1) ? {57'd0, len7} : accum_shift;
    assign len_too_long = len_final > {32'd0, max_frame_bytes};

    // Pick the key byte for this payload byte, first key byte first.
    always_comb begin
        case (key_index_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    assign left_dec = left_reg - 32'd1;

    // Advance the parse state by one byte.
    always_comb begin
        phase_next     = phase_reg;
        hdr_flags_next = hdr_flags_reg;
        opcode_next    = opcode_reg;
        accum_next     = accum_reg;
        ext_count_next = ext_count_reg;
        mask_key_next  = mask_key_reg;
        left_next      = left_reg;
        key_index_next = key_index_reg;
        failed_next    = failed_reg;
        res_valid      = 1'b0;
        res            = '0;
        res.frame_opcode = opcode_reg;

        if (fire && !failed_reg) begin
            unique case (phase_reg)
                dfr_pkg::PH_HDR0: begin
                    hdr_flags_next = in_byte_reg[7:4];
                    opcode_next    = in_byte_reg[3:0] & dfr_pkg::OPCODE_MASK;
                    phase_next     = dfr_pkg::PH_HDR1;
                end
                dfr_pkg::PH_HDR1: begin
                    if (({hdr_flags_reg, 4'd0} & dfr_pkg::RSV_MASK) != 8'd0 ||
                        ({hdr_flags_reg, 4'd0} & dfr_pkg::FIN_BIT) == 8'd0) begin
                        failed_next    = 1'b1;
                        res_valid      = 1'b1;
                        res.error_kind = dfr_pkg::ERR_HEADER;
                    end else if ((in_byte_reg & dfr_pkg::MASK_BIT) == 8'd0) begin
                        failed_next    = 1'b1;
                        res_valid      = 1'b1;
                        res.error_kind = dfr_pkg::ERR_UNMASKED;
                    end else if (len7 == dfr_pkg::LEN_EXT16 || len7 == dfr_pkg::LEN_EXT64) begin
                        accum_next     = '0;
                        ext_count_next = (len7 == dfr_pkg::LEN_EXT16) ?
                                         dfr_pkg::EXT16_REST : dfr_pkg::EXT64_REST;
                        phase_next     = dfr_pkg::PH_EXT;
                    end else if (len_too_long) begin
                        failed_next    = 1'b1;
                        res_valid      = 1'b1;
                        res.error_kind = dfr_pkg::ERR_TOO_LONG;
                    end else begin
                        accum_next     = len_final;
                        left_next      = len_final[31:0];
                        ext_count_next = '0;
                        phase_next     = dfr_pkg::PH_KEY;
                    end
                end
                dfr_pkg::PH_EXT: begin
                    accum_next = accum_shift;
                    if (ext_count_reg != 3'd0) begin
                        ext_count_next = ext_count_reg - 3'd1;
                    end else if (len_too_long) begin
                        failed_next    = 1'b1;
                        res_valid      = 1'b1;
                        res.error_kind = dfr_pkg::ERR_TOO_LONG;
                    end else begin
                        left_next  = len_final[31:0];
                        phase_next = dfr_pkg::PH_KEY;
                    end
                end
                dfr_pkg::PH_KEY: begin
                    mask_key_next  = {mask_key_reg[23:0], in_byte_reg};
                    key_index_next = key_index_reg + 2'd1;
                    if (key_index_reg == 2'd3) begin
                        if (left_reg == 32'd0) begin
                            phase_next     = dfr_pkg::PH_HDR0;
                            res_valid      = 1'b1;
                            res.frame_last = 1'b1;
                        end else begin
                            phase_next = dfr_pkg::PH_DATA;
                        end
                    end
                end
                dfr_pkg::PH_DATA: begin
                    key_index_next   = key_index_reg + 2'd1;
                    left_next        = left_dec;
                    res_valid        = 1'b1;
                    res.has_data     = 1'b1;
                    res.payload_byte = in_byte_reg ^ key_byte;
                    if (left_dec == 32'd0) begin
                        res.frame_last = 1'b1;
                        phase_next     = dfr_pkg::PH_HDR0;
                        key_index_next = 2'd0;
                    end
                end
                default: begin
                    phase_next = dfr_pkg::PH_HDR0;
                end
            endcase
        end
    end

    // Hold control state under reset, payload state free-running.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= dfr_pkg::PH_HDR0;
            ext_count_reg <= '0;
            key_index_reg <= '0;
            failed_reg    <= 1'b0;
            hdr_flags_reg <= '0;
            opcode_reg    <= '0;
            left_reg      <= '0;
        end else begin
            phase_reg     <= phase_next;
            ext_count_reg <= ext_count_next;
            key_index_reg <= key_index_next;
            failed_reg    <= failed_next;
            hdr_flags_reg <= hdr_flags_next;
            opcode_reg    <= opcode_next;
            left_reg      <= left_next;
        end
        accum_reg    <= accum_next;
        mask_key_reg <= mask_key_next;
    end

    `DFR_ASSERT(a_failed_sticky, aclk, aresetn, failed_reg |=> failed_reg, "error flag cleared")
    `DFR_ASSERT(a_key_idx_phase, aclk, aresetn, (key_index_reg != 2'd0) |-> (phase_reg == dfr_pkg::PH_KEY || phase_reg == dfr_pkg::PH_DATA), "key index outside key or data phase")
    `DFR_ASSERT(a_ext_cnt_phase, aclk, aresetn, (ext_count_reg != 3'd0) |-> (phase_reg == dfr_pkg::PH_EXT), "extended count outside length phase")

endmodule

// File: hdl/dfr_out_buf.sv
// Result buffer: output register with a skid stage behind it.
`include "assert_macros.svh"

module dfr_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  dfr_pkg::result_t   in_data,
    output logic               in_ready,
    output logic               out_valid,
    output dfr_pkg::result_t   out_data,
    input  logic               out_ready
);

    logic              out_valid_reg;
    dfr_pkg::result_t  out_data_reg;
    logic              skid_valid_reg;
    dfr_pkg::result_t  skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Refill the output from the skid stage first; park a transfer when stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end

        if (!out_valid_reg || out_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

    `DFR_ASSERT(a_skid_behind, aclk, aresetn,
                skid_valid_reg |-> out_valid_reg, "skid stage full with output empty")
    `DFR_ASSERT(a_no_overrun, aclk, aresetn,
                in_valid |-> !skid_valid_reg, "result pushed while buffer full")
    `DFR_ASSERT(a_out_hold, aclk, aresetn,
                (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_data_reg)),
                "stalled result changed")

endmodule

// File: hdl/websocket_frame_deframer.sv
// Top level: byte stream in, unmasked payload results out, frame limit register.
// Path: a result is registered through the input register, then the result register,
// with the parser between them; results wait in the output or skid stage while stalled.
// Throughput: one byte per cycle unless results stall, set by the single-pass parser.
// Reset (aresetn low, synchronous): parser back to the first header byte, error flag
// cleared, both buffers empty, max_frame_bytes back to 65536.
module websocket_frame_deframer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] payload_byte
    output logic                           m_tlast,   // frame_last
    output logic [dfr_pkg::USER_W-1:0]     m_tuser,   // [0] has_data, [4:1] frame_opcode,
                                                      // [6:5] error_kind
    // Configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [31:0]                    cfg_data   // max_frame_bytes
);

    logic              buf_ready;
    logic              res_valid;
    dfr_pkg::result_t  res;
    dfr_pkg::result_t  out_res;
    logic [31:0]       max_frame_reg;

    // Take a limit write in any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_reg <= dfr_pkg::MAX_FRAME_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_frame_reg <= cfg_data;
        end
    end

    dfr_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .max_frame_bytes (max_frame_reg),
        .buf_ready       (buf_ready),
        .res_valid       (res_valid),
        .res             (res)
    );

    dfr_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (buf_ready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    // Pack the result onto the stream ports.
    assign m_tdata = out_res.payload_byte;
    assign m_tlast = out_res.frame_last;
    assign m_tuser = {out_res.error_kind, out_res.frame_opcode, out_res.has_data};

endmodule
